### src/gcd_pkg.sv
// Shared types, widths and constant tables for the great-circle distance unit.
// No dependencies; imported by every module of the block.
package gcd_pkg;

  // Fixed-point angle format: value * 2^ANGLE_FRAC_BITS
  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_STAGES   = 32;

  // Field widths
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 31;
  localparam int RAD_W  = 23;
  localparam int UNIT_W = 31;   // folded angle in 1e-7 degree units

  // Internal widths
  localparam int ANG_W  = ANGLE_FRAC_BITS + 4;      // CORDIC x/y/z
  localparam int MAG_W  = ANGLE_FRAC_BITS + 1;      // magnitudes, h, roots
  localparam int PRD_W  = ANGLE_FRAC_BITS + 2;      // rounded products
  localparam int REM_W  = 2 * ANGLE_FRAC_BITS + 3;  // square root remainder
  localparam int RSC_W  = 31;                       // 200 * radius

  localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C235;
  localparam logic [63:0] FULL_UNITS    = 64'd3600000000;
  localparam logic [63:0] HALF_UNITS    = 64'd1800000000;
  localparam logic [63:0] QUARTER_UNITS = 64'd900000000;

  // pi / 3.6e9 in Q93
  localparam logic [63:0] RAD_Q93 = ((PI_Q62 / FULL_UNITS) << 31) +
                                    (((PI_Q62 % FULL_UNITS) << 31) / FULL_UNITS);
  localparam int RAD_SHIFT = 93 - ANGLE_FRAC_BITS;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = 23'd6378137;
  localparam logic [DIST_W-1:0] DIST_MAX     = 31'd2100000000;

  // Sideband that travels with each word
  typedef struct packed {
    logic no_fix;
    logic sign_diff;
  } gcd_sb_t;

  // Restoring long division, used only when building constant tables
  function automatic logic [63:0] const_div(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // CORDIC arctangent of 2^-i in Q(ANGLE_FRAC_BITS), from a Q62 series
  function automatic logic signed [ANG_W-1:0] atn_q(input int i);
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] r;
    int          e;
    v = '0;
    if (i == 0) begin
      v = PI_Q62 >> 2;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          t = const_div(64'd1 << (62 - e), 64'(2 * k + 1));
          if ((k & 1) != 0) v = v - t;
          else              v = v + t;
        end
      end
    end
    r = (v + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
    return signed'(r[ANG_W-1:0]);
  endfunction

  // Inverse squared CORDIC gain in Q62 for n stages
  function automatic logic [63:0] inv_gain2(input int n);
    logic [63:0]  g;
    logic [63:0]  f;
    logic [63:0]  one;
    logic [127:0] p;
    one = 64'd1 << 62;
    g   = one;
    for (int i = 0; i < 64; i++) begin
      if (i < n && 2 * i <= 62) begin
        f = one - const_div(one, (64'd1 << (2 * i)) + 64'd1);
        p = {64'd0, g} * {64'd0, f} + (128'd1 << 61);
        g = p[125:62];
      end
    end
    return g;
  endfunction

endpackage

### src/gcd_rotate.sv
// CORDIC rotation pipeline, one stage per iteration, several lanes side by side.
// Depends on gcd_pkg (widths, sideband type, arctangent table).
module gcd_rotate #(
  parameter int STAGES = 32,
  parameter int LANES  = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               vld_in,
  input  gcd_pkg::gcd_sb_t                   sb_in,
  input  logic signed [gcd_pkg::ANG_W-1:0]   z_in  [LANES],
  output logic                               vld_out,
  output gcd_pkg::gcd_sb_t                   sb_out,
  output logic signed [gcd_pkg::ANG_W-1:0]   x_out [LANES],
  output logic signed [gcd_pkg::ANG_W-1:0]   y_out [LANES]
);
  import gcd_pkg::*;

  localparam logic signed [ANG_W-1:0] ONE = ANG_W'(1) << ANGLE_FRAC_BITS;

  logic                    v_r  [STAGES];
  gcd_sb_t                 sb_r [STAGES];
  logic signed [ANG_W-1:0] x_r  [STAGES][LANES];
  logic signed [ANG_W-1:0] y_r  [STAGES][LANES];
  logic signed [ANG_W-1:0] z_r  [STAGES][LANES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATN = atn_q(s);
    logic                    vi;
    gcd_sb_t                 sbi;
    logic signed [ANG_W-1:0] xi [LANES];
    logic signed [ANG_W-1:0] yi [LANES];
    logic signed [ANG_W-1:0] zi [LANES];

    // stage input: start vector (1, 0) or previous stage
    if (s == 0) begin : g_in
      assign vi  = vld_in;
      assign sbi = sb_in;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign xi[l] = ONE;
        assign yi[l] = '0;
        assign zi[l] = z_in[l];
      end
    end else begin : g_in
      assign vi  = v_r[s-1];
      assign sbi = sb_r[s-1];
      assign xi  = x_r[s-1];
      assign yi  = y_r[s-1];
      assign zi  = z_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    // one micro-rotation, direction from the residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sbi;
        for (int l = 0; l < LANES; l++) begin
          if (zi[l] >= 0) begin
            x_r[s][l] <= xi[l] - (yi[l] >>> s);
            y_r[s][l] <= yi[l] + (xi[l] >>> s);
            z_r[s][l] <= zi[l] - ATN;
          end else begin
            x_r[s][l] <= xi[l] + (yi[l] >>> s);
            y_r[s][l] <= yi[l] - (xi[l] >>> s);
            z_r[s][l] <= zi[l] + ATN;
          end
        end
      end
    end
  end

  assign vld_out = v_r[STAGES-1];
  assign sb_out  = sb_r[STAGES-1];
  assign x_out   = x_r[STAGES-1];
  assign y_out   = y_r[STAGES-1];

endmodule

### src/gcd_sqrt.sv
// Bit-per-stage floor square root of a Q(F) value, result in Q(F).
// Depends on gcd_pkg (widths, sideband type).
module gcd_sqrt #(
  parameter int LANES = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_in,
  input  gcd_pkg::gcd_sb_t                 sb_in,
  input  logic [gcd_pkg::MAG_W-1:0]        rad_in  [LANES],
  output logic                             vld_out,
  output gcd_pkg::gcd_sb_t                 sb_out,
  output logic [gcd_pkg::MAG_W-1:0]        root_out [LANES]
);
  import gcd_pkg::*;

  localparam int STAGES = ANGLE_FRAC_BITS + 1;

  logic             v_r   [STAGES];
  gcd_sb_t          sb_r  [STAGES];
  logic [MAG_W-1:0] r_r   [STAGES][LANES];
  logic [REM_W-1:0] rem_r [STAGES][LANES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int B = ANGLE_FRAC_BITS - s;
    logic             vi;
    gcd_sb_t          sbi;
    logic [MAG_W-1:0] ri   [LANES];
    logic [REM_W-1:0] remi [LANES];
    logic [REM_W-1:0] tv   [LANES];

    if (s == 0) begin : g_in
      assign vi  = vld_in;
      assign sbi = sb_in;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign ri[l]   = '0;
        assign remi[l] = REM_W'(rad_in[l]) << ANGLE_FRAC_BITS;
      end
    end else begin : g_in
      assign vi   = v_r[s-1];
      assign sbi  = sb_r[s-1];
      assign ri   = r_r[s-1];
      assign remi = rem_r[s-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    for (genvar l = 0; l < LANES; l++) begin : g_tv
      assign tv[l] = (REM_W'(ri[l]) << (B + 1)) + (REM_W'(1) << (2 * B));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    // keep the trial bit when its square still fits
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sbi;
        for (int l = 0; l < LANES; l++) begin
          if (remi[l] >= tv[l]) begin
            rem_r[s][l] <= remi[l] - tv[l];
            r_r[s][l]   <= ri[l] | (MAG_W'(1) << B);
          end else begin
            rem_r[s][l] <= remi[l];
            r_r[s][l]   <= ri[l];
          end
        end
      end
    end
  end

  assign vld_out  = v_r[STAGES-1];
  assign sb_out   = sb_r[STAGES-1];
  assign root_out = r_r[STAGES-1];

endmodule

### src/gcd_vector.sv
// CORDIC vectoring pipeline: angle of (x, y), one stage per iteration.
// Depends on gcd_pkg (widths, sideband type, arctangent table).
module gcd_vector #(
  parameter int STAGES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_in,
  input  gcd_pkg::gcd_sb_t                 sb_in,
  input  logic [gcd_pkg::MAG_W-1:0]        x_in,
  input  logic [gcd_pkg::MAG_W-1:0]        y_in,
  output logic                             vld_out,
  output gcd_pkg::gcd_sb_t                 sb_out,
  output logic signed [gcd_pkg::ANG_W-1:0] z_out
);
  import gcd_pkg::*;

  logic                    v_r  [STAGES];
  gcd_sb_t                 sb_r [STAGES];
  logic signed [ANG_W-1:0] x_r  [STAGES];
  logic signed [ANG_W-1:0] y_r  [STAGES];
  logic signed [ANG_W-1:0] z_r  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATN = atn_q(s);
    logic                    vi;
    gcd_sb_t                 sbi;
    logic signed [ANG_W-1:0] xi;
    logic signed [ANG_W-1:0] yi;
    logic signed [ANG_W-1:0] zi;

    if (s == 0) begin : g_in
      assign vi  = vld_in;
      assign sbi = sb_in;
      assign xi  = signed'(ANG_W'(x_in));
      assign yi  = signed'(ANG_W'(y_in));
      assign zi  = '0;
    end else begin : g_in
      assign vi  = v_r[s-1];
      assign sbi = sb_r[s-1];
      assign xi  = x_r[s-1];
      assign yi  = y_r[s-1];
      assign zi  = z_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    // drive y toward zero, accumulate the angle
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[s] <= sbi;
        if (yi >= 0) begin
          x_r[s] <= xi + (yi >>> s);
          y_r[s] <= yi - (xi >>> s);
          z_r[s] <= zi + ATN;
        end else begin
          x_r[s] <= xi - (yi >>> s);
          y_r[s] <= yi + (xi >>> s);
          z_r[s] <= zi - ATN;
        end
      end
    end
  end

  assign vld_out = v_r[STAGES-1];
  assign sb_out  = sb_r[STAGES-1];
  assign z_out   = z_r[STAGES-1];

endmodule

### src/great_circle_distance_unit.sv
// Haversine great-circle distance, fully pipelined.
// From accept to out_valid a word passes the input stages, the CORDIC rotation, the product stages,
// the bit-per-stage square root, the CORDIC vectoring, the radius scaling and the output buffer.
// Throughput: one word per cycle; a two-word output buffer freezes the pipeline when full.
// Reset (synchronous, rst_n low): all valid bits and the buffer clear, radius = 6378137 m.
// Depends on gcd_pkg, gcd_rotate, gcd_sqrt, gcd_vector.
module great_circle_distance_unit #(
  parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [gcd_pkg::RAD_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [gcd_pkg::LAT_W-1:0]    in_first_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]    in_first_longitude,
  input  logic signed [gcd_pkg::LAT_W-1:0]    in_second_latitude,
  input  logic signed [gcd_pkg::LON_W-1:0]    in_second_longitude,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gcd_pkg::DIST_W-1:0]          out_distance_cm,
  output logic                                out_no_fix
);
  import gcd_pkg::*;

  localparam logic [63:0] IG2    = inv_gain2(CORDIC_STAGES);
  localparam logic [30:0] IG2_LO = IG2[30:0];
  localparam logic [30:0] IG2_HI = IG2[61:31];
  localparam logic [31:0] RQ_LO  = RAD_Q93[31:0];
  localparam logic [30:0] RQ_HI  = RAD_Q93[62:32];
  localparam logic [MAG_W:0] ONE_Q = (MAG_W+1)'(1) << ANGLE_FRAC_BITS;

  logic en;
  logic accept;

  // ---------------- radius register, kept as 200 * R ----------------
  logic [RSC_W-1:0] rsc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsc_r <= RSC_W'(RADIUS_RESET) * RSC_W'(200);
    end else if (cfg_wr_en) begin
      rsc_r <= RSC_W'(cfg_wr_data) * RSC_W'(200);
    end
  end

  assign accept = in_valid & ~in_stall;

  // ---------------- stage 1: differences, folding ----------------
  logic signed [LAT_W:0] dla;
  logic signed [LON_W:0] dlo;
  logic [LAT_W:0]        dla_abs;
  logic [LON_W:0]        dlo_abs;
  logic [LON_W:0]        dlo_mod;
  logic [LAT_W-1:0]      lat1_abs;
  logic [LAT_W-1:0]      lat2_abs;
  logic [LAT_W-1:0]      lat1_f;
  logic [LAT_W-1:0]      lat2_f;
  logic                  neg1;
  logic                  neg2;
  logic [UNIT_W-1:0]     u_nxt [4];
  gcd_sb_t               sb1_nxt;

  always_comb begin
    dla     = {in_first_latitude[LAT_W-1], in_first_latitude}
            - {in_second_latitude[LAT_W-1], in_second_latitude};
    dlo     = {in_first_longitude[LON_W-1], in_first_longitude}
            - {in_second_longitude[LON_W-1], in_second_longitude};
    dla_abs = dla[LAT_W] ? unsigned'(-dla) : unsigned'(dla);
    dlo_abs = dlo[LON_W] ? unsigned'(-dlo) : unsigned'(dlo);
    // longitude difference wraps modulo a full turn
    dlo_mod = (dlo_abs >= (LON_W+1)'(FULL_UNITS)) ? dlo_abs - (LON_W+1)'(FULL_UNITS) : dlo_abs;
    u_nxt[0] = (dla_abs > (LAT_W+1)'(HALF_UNITS)) ?
               UNIT_W'((LAT_W+1)'(FULL_UNITS) - dla_abs) : UNIT_W'(dla_abs);
    u_nxt[1] = (dlo_mod > (LON_W+1)'(HALF_UNITS)) ?
               UNIT_W'((LON_W+1)'(FULL_UNITS) - dlo_mod) : UNIT_W'(dlo_mod);
    // latitudes past a quarter turn mirror, cosine sign noted
    lat1_abs = in_first_latitude[LAT_W-1]  ? unsigned'(-in_first_latitude)
                                           : unsigned'(in_first_latitude);
    lat2_abs = in_second_latitude[LAT_W-1] ? unsigned'(-in_second_latitude)
                                           : unsigned'(in_second_latitude);
    neg1   = lat1_abs > LAT_W'(QUARTER_UNITS);
    neg2   = lat2_abs > LAT_W'(QUARTER_UNITS);
    lat1_f = neg1 ? LAT_W'(HALF_UNITS) - lat1_abs : lat1_abs;
    lat2_f = neg2 ? LAT_W'(HALF_UNITS) - lat2_abs : lat2_abs;
    u_nxt[2] = UNIT_W'({lat1_f, 1'b0});
    u_nxt[3] = UNIT_W'({lat2_f, 1'b0});
    sb1_nxt.no_fix    = (in_first_latitude == '0);
    sb1_nxt.sign_diff = neg1 ^ neg2;
  end

  logic              v1_r;
  gcd_sb_t           sb1_r;
  logic [UNIT_W-1:0] u1_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= accept;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r <= sb1_nxt;
      u1_r  <= u_nxt;
    end
  end

  // ---------------- stage 2: degree to radian partial products ----------------
  logic        v2_r;
  gcd_sb_t     sb2_r;
  logic [62:0] plo2_r [4];
  logic [61:0] phi2_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r <= sb1_r;
      for (int l = 0; l < 4; l++) begin
        plo2_r[l] <= 63'(u1_r[l]) * 63'(RQ_LO);
        phi2_r[l] <= 62'(u1_r[l]) * 62'(RQ_HI);
      end
    end
  end

  // ---------------- stage 3: combine, round to Q(F) ----------------
  logic                    v3_r;
  gcd_sb_t                 sb3_r;
  logic signed [ANG_W-1:0] z3_r [4];
  logic [94:0]             rsum [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rsum[l] = (95'(phi2_r[l]) << 32) + 95'(plo2_r[l]) + (95'd1 << (RAD_SHIFT - 1));
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb3_r <= sb2_r;
      for (int l = 0; l < 4; l++) begin
        z3_r[l] <= signed'(ANG_W'(rsum[l] >> RAD_SHIFT));
      end
    end
  end

  // ---------------- rotation: sines of half differences, cosines of latitudes ----------------
  logic                    v4;
  gcd_sb_t                 sb4;
  logic signed [ANG_W-1:0] rx [4];
  logic signed [ANG_W-1:0] ry [4];

  gcd_rotate #(
    .STAGES (CORDIC_STAGES),
    .LANES  (4)
  ) u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (v3_r),
    .sb_in   (sb3_r),
    .z_in    (z3_r),
    .vld_out (v4),
    .sb_out  (sb4),
    .x_out   (rx),
    .y_out   (ry)
  );

  // ---------------- stage 5: squares and cosine product ----------------
  logic [MAG_W-1:0] m4 [4];
  always_comb begin
    m4[0] = (ry[0] < 0) ? '0 : MAG_W'(ry[0]);
    m4[1] = (ry[1] < 0) ? '0 : MAG_W'(ry[1]);
    m4[2] = (rx[2] < 0) ? '0 : MAG_W'(rx[2]);
    m4[3] = (rx[3] < 0) ? '0 : MAG_W'(rx[3]);
  end

  logic             v5_r;
  gcd_sb_t          sb5_r;
  logic [PRD_W-1:0] p5_r [3];
  logic [63:0]      sq [3];
  always_comb begin
    sq[0] = 64'(m4[0]) * 64'(m4[0]) + (64'd1 << (ANGLE_FRAC_BITS - 1));
    sq[1] = 64'(m4[1]) * 64'(m4[1]) + (64'd1 << (ANGLE_FRAC_BITS - 1));
    sq[2] = 64'(m4[2]) * 64'(m4[3]) + (64'd1 << (ANGLE_FRAC_BITS - 1));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb5_r <= sb4;
      for (int l = 0; l < 3; l++) p5_r[l] <= PRD_W'(sq[l] >> ANGLE_FRAC_BITS);
    end
  end

  // ---------------- stage 6: gain correction partial products ----------------
  logic        v6_r;
  gcd_sb_t     sb6_r;
  logic [62:0] glo6_r [3];
  logic [62:0] ghi6_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb6_r <= sb5_r;
      for (int l = 0; l < 3; l++) begin
        glo6_r[l] <= 63'(p5_r[l]) * 63'(IG2_LO);
        ghi6_r[l] <= 63'(p5_r[l]) * 63'(IG2_HI);
      end
    end
  end

  // ---------------- stage 7: gain correction combine ----------------
  logic             v7_r;
  gcd_sb_t          sb7_r;
  logic [PRD_W-1:0] g7_r [3];
  logic [94:0]      gsum [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      gsum[l] = (95'(ghi6_r[l]) << 31) + 95'(glo6_r[l]) + (95'd1 << 61);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en) v7_r <= v6_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb7_r <= sb6_r;
      for (int l = 0; l < 3; l++) g7_r[l] <= PRD_W'(gsum[l] >> 62);
    end
  end

  // ---------------- stage 8: cos*cos*hav(dlon) ----------------
  logic             v8_r;
  gcd_sb_t          sb8_r;
  logic [PRD_W-1:0] sa8_r;
  logic [PRD_W-1:0] term8_r;
  logic [63:0]      tprod;
  assign tprod = 64'(g7_r[2]) * 64'(g7_r[1]) + (64'd1 << (ANGLE_FRAC_BITS - 1));
  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else if (en) v8_r <= v7_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb8_r   <= sb7_r;
      sa8_r   <= g7_r[0];
      term8_r <= PRD_W'(tprod >> ANGLE_FRAC_BITS);
    end
  end

  // ---------------- stage 9: h and 1 - h, clamped to [0, 1] ----------------
  logic [PRD_W:0]   hsum;
  logic [MAG_W-1:0] hcl;
  always_comb begin
    if (sb8_r.sign_diff) begin
      hsum = (sa8_r > term8_r) ? (PRD_W+1)'(sa8_r - term8_r) : '0;
    end else begin
      hsum = (PRD_W+1)'(sa8_r) + (PRD_W+1)'(term8_r);
    end
    hcl = (hsum > (PRD_W+1)'(ONE_Q)) ? MAG_W'(ONE_Q) : MAG_W'(hsum);
  end

  logic             v9_r;
  gcd_sb_t          sb9_r;
  logic [MAG_W-1:0] h9_r [2];
  always_ff @(posedge clk) begin
    if (!rst_n) v9_r <= 1'b0;
    else if (en) v9_r <= v8_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb9_r   <= sb8_r;
      h9_r[0] <= hcl;
      h9_r[1] <= MAG_W'(ONE_Q) - hcl;
    end
  end

  // ---------------- square roots of h and 1 - h ----------------
  logic             v10;
  gcd_sb_t          sb10;
  logic [MAG_W-1:0] root [2];

  gcd_sqrt #(
    .LANES (2)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (v9_r),
    .sb_in    (sb9_r),
    .rad_in   (h9_r),
    .vld_out  (v10),
    .sb_out   (sb10),
    .root_out (root)
  );

  // ---------------- asin(sqrt(h)) by vectoring ----------------
  logic                    v11;
  gcd_sb_t                 sb11;
  logic signed [ANG_W-1:0] zang;

  gcd_vector #(
    .STAGES (CORDIC_STAGES)
  ) u_vector (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (v10),
    .sb_in   (sb10),
    .x_in    (root[1]),
    .y_in    (root[0]),
    .vld_out (v11),
    .sb_out  (sb11),
    .z_out   (zang)
  );

  // ---------------- stage 12: angle times 200 * R ----------------
  logic [MAG_W-1:0] zmag;
  assign zmag = (zang < 0) ? '0 : MAG_W'(zang);

  logic        v12_r;
  gcd_sb_t     sb12_r;
  logic [63:0] d12_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v12_r <= 1'b0;
    else if (en) v12_r <= v11;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb12_r <= sb11;
      d12_r  <= 64'(zmag) * 64'(rsc_r);
    end
  end

  // round to whole centimeters, saturate, force zero without a fix
  logic [63:0]       dround;
  logic [DIST_W-1:0] dist_fin;
  always_comb begin
    dround = (d12_r + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
    if (sb12_r.no_fix) begin
      dist_fin = '0;
    end else if (dround > 64'(DIST_MAX)) begin
      dist_fin = DIST_MAX;
    end else begin
      dist_fin = DIST_W'(dround);
    end
  end

  // ---------------- two-word output buffer ----------------
  logic [DIST_W-1:0] fd_r  [2];
  logic              fnf_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic              push;
  logic              pop;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = ~en;
  assign push     = v12_r & en;
  assign pop      = out_valid & ~out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fd_r[wr_ptr_r]  <= dist_fin;
      fnf_r[wr_ptr_r] <= sb12_r.no_fix;
    end
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_distance_cm = fd_r[rd_ptr_r];
  assign out_no_fix      = fnf_r[rd_ptr_r];

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("output buffer count out of range");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !pop |=> (cnt_r == 2'd2))
    else $error("full buffer changed without a pop");

  a_no_fix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_fix |-> (out_distance_cm == '0))
    else $error("no-fix word carries a distance");

  a_dist_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance_cm <= DIST_MAX))
    else $error("distance above saturation limit");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v12_r))
    else $error("pipeline moved while frozen");

endmodule
